// ===== design/hdf_pkg.sv =====
// ----------------------------------------------------------------------------
// hdf_pkg
// Shared types and constants of the heading damping filter.
// ----------------------------------------------------------------------------
package hdf_pkg;

  localparam int BEARING_W   = 18;
  localparam int VAL_W       = 19;
  localparam int WEIGHT_W    = 16;
  localparam int NUM_WEIGHTS = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int ACC_W       = 40;
  localparam int PROD_W      = VAL_W + WEIGHT_W + 1;
  localparam int Q_SHIFT     = 15;

  localparam int FULL_TURN   = 36000;
  localparam int HALF_TURN   = 18000;
  localparam int ZERO_BAND   = 140;
  localparam int BEARING_MAX = 131071;
  localparam int BEARING_MIN = -131072;

  typedef logic signed [BEARING_W-1:0] bearing_t;
  typedef logic signed [VAL_W-1:0]     val_t;
  typedef logic        [WEIGHT_W-1:0]  weight_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic signed [PROD_W-1:0]    prod_t;

  localparam acc_t TURN_Q = acc_t'(FULL_TURN) <<< Q_SHIFT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_W_OLDEST   = 3'd0,
    REG_W_SECOND   = 3'd1,
    REG_W_MIDDLE   = 3'd2,
    REG_W_PREVIOUS = 3'd3,
    REG_W_NEWEST   = 3'd4
  } cfg_reg_e;

  localparam weight_t W_RESET [NUM_WEIGHTS] = '{
    16'd0, 16'd0, 16'd0, 16'd3277, 16'd29491
  };

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic turn_dn;
    logic turn_up;
  } mac_ctrl_t;

endpackage

// ===== design/hdf_intf.sv =====
// ----------------------------------------------------------------------------
// hdf interfaces
// Valid/ready channels for bearing input, bearing output and weight writes.
// ----------------------------------------------------------------------------
interface hdf_in_if;
  logic              valid;
  logic              ready;
  hdf_pkg::bearing_t bearing_in;

  modport source (output valid, output bearing_in, input ready);
  modport sink   (input valid, input bearing_in, output ready);
endinterface

interface hdf_out_if;
  logic              valid;
  logic              ready;
  hdf_pkg::bearing_t bearing_out;

  modport source (output valid, output bearing_out, input ready);
  modport sink   (input valid, input bearing_out, output ready);
endinterface

interface hdf_cfg_if;
  logic              valid;
  logic              ready;
  hdf_pkg::cfg_idx_t index;
  hdf_pkg::weight_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/hdf_weights.sv =====
// ----------------------------------------------------------------------------
// hdf_weights
// Slot weight registers, written over the config channel, one read port.
// ----------------------------------------------------------------------------
module hdf_weights (
  input  logic              clk_i,
  input  logic              rst_ni,
  hdf_cfg_if.sink           cfg_i,
  input  hdf_pkg::cfg_idx_t rd_idx_i,
  output hdf_pkg::weight_t  weight_o
);

  hdf_pkg::weight_t w_q [hdf_pkg::NUM_WEIGHTS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= hdf_pkg::W_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (hdf_pkg::cfg_reg_e'(cfg_i.index))
        hdf_pkg::REG_W_OLDEST:   w_q[0] <= cfg_i.data;
        hdf_pkg::REG_W_SECOND:   w_q[1] <= cfg_i.data;
        hdf_pkg::REG_W_MIDDLE:   w_q[2] <= cfg_i.data;
        hdf_pkg::REG_W_PREVIOUS: w_q[3] <= cfg_i.data;
        hdf_pkg::REG_W_NEWEST:   w_q[4] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign weight_o = (rd_idx_i < hdf_pkg::CFG_IDX_W'(hdf_pkg::NUM_WEIGHTS)) ?
                    w_q[rd_idx_i] : '0;

endmodule

// ===== design/hdf_mac.sv =====
// ----------------------------------------------------------------------------
// hdf_mac
// Shared multiply-accumulate unit: registered product, accumulator with
// full-turn correction.
// ----------------------------------------------------------------------------
module hdf_mac (
  input  logic               clk_i,
  input  hdf_pkg::mac_ctrl_t ctrl_i,
  input  hdf_pkg::val_t      val_i,
  input  hdf_pkg::weight_t   weight_i,
  output hdf_pkg::acc_t      acc_o
);

  hdf_pkg::prod_t prod_q;
  hdf_pkg::acc_t  acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= val_i * $signed({1'b0, weight_i});
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + hdf_pkg::acc_t'(prod_q);
    end else if (ctrl_i.turn_dn) begin
      acc_q <= acc_q - hdf_pkg::TURN_Q;
    end else if (ctrl_i.turn_up) begin
      acc_q <= acc_q + hdf_pkg::TURN_Q;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== design/heading_damping_filter.sv =====
// ----------------------------------------------------------------------------
// heading_damping_filter
// Damps compass bearings (centidegrees) with a weighted ring of recent values.
// ----------------------------------------------------------------------------
// Channel     Dir  Payload                  Beat
// bearing_i   in   bearing_in  (s18)        one raw bearing
// bearing_o   out  bearing_out (s18)        one damped bearing
// cfg_i       in   index (3), data (16)     one weight register write
//
// One item occupies the block from acceptance until its result is registered:
// the single multiply-accumulate unit takes one ring slot per cycle.
// bearing_i is ready only while idle; the result sits in an output register,
// so the next beat is taken while it waits. A full output register stalls
// the final step until it drains. Reset leaves the ring unprimed.
// ----------------------------------------------------------------------------
module heading_damping_filter #(
  parameter int RING_DEPTH = 5
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  hdf_in_if.sink   bearing_i,
  hdf_out_if.source bearing_o,
  hdf_cfg_if.sink  cfg_i
);

  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam slot_t OFF_ONE   = slot_t'(1);
  localparam slot_t OFF_PREV1 = slot_t'(RING_DEPTH - 1);
  localparam slot_t OFF_PREV2 = slot_t'(RING_DEPTH - 2);
  localparam cnt_t  CNT_LAST  = cnt_t'(RING_DEPTH - 1);
  localparam cnt_t  CNT_END   = cnt_t'(RING_DEPTH);
  localparam hdf_pkg::cfg_idx_t W_BASE =
    hdf_pkg::CFG_IDX_W'(hdf_pkg::NUM_WEIGHTS - RING_DEPTH);
  localparam hdf_pkg::bearing_t TURN_B = hdf_pkg::bearing_t'(hdf_pkg::FULL_TURN);
  localparam hdf_pkg::val_t TURN_V = hdf_pkg::val_t'(hdf_pkg::FULL_TURN);
  localparam hdf_pkg::val_t HALF_V = hdf_pkg::val_t'(hdf_pkg::HALF_TURN);
  localparam hdf_pkg::bearing_t BAND_HI = hdf_pkg::bearing_t'(hdf_pkg::ZERO_BAND);
  localparam hdf_pkg::bearing_t BAND_LO = hdf_pkg::bearing_t'(-hdf_pkg::ZERO_BAND);
  localparam hdf_pkg::acc_t TURN_A = hdf_pkg::acc_t'(hdf_pkg::FULL_TURN);
  localparam hdf_pkg::acc_t SAT_HI = hdf_pkg::acc_t'(hdf_pkg::BEARING_MAX);
  localparam hdf_pkg::acc_t SAT_LO = hdf_pkg::acc_t'(hdf_pkg::BEARING_MIN);
  localparam hdf_pkg::acc_t FRAC_MASK =
    (hdf_pkg::acc_t'(1) <<< hdf_pkg::Q_SHIFT) - hdf_pkg::acc_t'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_PREV,
    ST_MAC,
    ST_FIX,
    ST_DONE
  } state_e;

  function automatic slot_t slot_add(input slot_t a, input slot_t b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SLOT_W + 1)'(RING_DEPTH)) begin
      s = s - (SLOT_W + 1)'(RING_DEPTH);
    end
    return s[SLOT_W-1:0];
  endfunction

  function automatic hdf_pkg::bearing_t sat_val(input hdf_pkg::acc_t v);
    hdf_pkg::bearing_t r;
    if (v > SAT_HI) begin
      r = hdf_pkg::bearing_t'(hdf_pkg::BEARING_MAX);
    end else if (v < SAT_LO) begin
      r = hdf_pkg::bearing_t'(hdf_pkg::BEARING_MIN);
    end else begin
      r = v[hdf_pkg::BEARING_W-1:0];
    end
    return r;
  endfunction

  state_e            state_q;
  logic              not_primed_q;
  slot_t             slot_q;
  cnt_t              j_q;
  logic              out_valid_q;
  hdf_pkg::bearing_t out_q;
  hdf_pkg::bearing_t ring_q [RING_DEPTH];
  slot_t             cur_q;
  slot_t             base_q;
  hdf_pkg::bearing_t p_q;

  hdf_pkg::bearing_t  raw;
  hdf_pkg::bearing_t  wrapped;
  slot_t              rd_slot;
  hdf_pkg::bearing_t  rd_val;
  hdf_pkg::bearing_t  zero_fix;
  hdf_pkg::val_t      term;
  hdf_pkg::val_t      term_p;
  hdf_pkg::cfg_idx_t  w_idx;
  hdf_pkg::weight_t   w_val;
  hdf_pkg::mac_ctrl_t mac_ctrl;
  hdf_pkg::acc_t      acc;
  logic               acc_hi;
  logic               acc_neg;
  hdf_pkg::acc_t      quot;
  hdf_pkg::bearing_t  newest;
  logic               in_fire;
  logic               out_free;

  assign in_fire  = bearing_i.valid && bearing_i.ready;
  assign out_free = !out_valid_q || bearing_o.ready;

  assign bearing_i.ready       = (state_q == ST_IDLE);
  assign bearing_o.valid       = out_valid_q;
  assign bearing_o.bearing_out = out_q;

  // Single wrap into one turn
  always_comb begin
    raw = bearing_i.bearing_in;
    if (raw < 0) begin
      wrapped = raw + TURN_B;
    end else if (raw >= TURN_B) begin
      wrapped = raw - TURN_B;
    end else begin
      wrapped = raw;
    end
  end

  // Ring read port
  always_comb begin
    case (state_q)
      ST_ZERO: rd_slot = slot_add(cur_q, OFF_PREV2);
      ST_PREV: rd_slot = slot_add(cur_q, OFF_PREV1);
      default: rd_slot = slot_add(base_q, j_q[SLOT_W-1:0]);
    endcase
  end

  assign rd_val = ring_q[rd_slot];

  assign zero_fix = ((ring_q[cur_q] == '0) && ((rd_val > BAND_HI) || (rd_val < BAND_LO))) ?
                    rd_val : ring_q[cur_q];

  // Newest term unwrapped against the slot before it
  always_comb begin
    term   = hdf_pkg::val_t'(rd_val);
    term_p = hdf_pkg::val_t'(p_q);
    if (j_q == CNT_LAST) begin
      if (term_p > term + HALF_V) begin
        term = term + TURN_V;
      end else if (term_p + HALF_V < term) begin
        term = term - TURN_V;
      end
    end
  end

  assign w_idx = W_BASE + hdf_pkg::CFG_IDX_W'(j_q);

  hdf_weights u_weights (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .rd_idx_i (w_idx),
    .weight_o (w_val)
  );

  assign acc_hi  = (acc >= hdf_pkg::TURN_Q);
  assign acc_neg = acc[hdf_pkg::ACC_W-1];

  always_comb begin
    mac_ctrl = '0;
    case (state_q)
      ST_PREV: mac_ctrl.clear = 1'b1;
      ST_MAC: begin
        mac_ctrl.mul_en = (j_q != CNT_END);
        mac_ctrl.acc_en = (j_q != '0);
      end
      ST_FIX: begin
        mac_ctrl.turn_dn = acc_hi;
        mac_ctrl.turn_up = !acc_hi && acc_neg;
      end
      default: ;
    endcase
  end

  hdf_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .val_i    (term),
    .weight_i (w_val),
    .acc_o    (acc)
  );

  // Truncate toward zero, then saturate
  always_comb begin
    quot = acc >>> hdf_pkg::Q_SHIFT;
    if (acc_neg && ((acc & FRAC_MASK) != '0)) begin
      quot = quot + hdf_pkg::acc_t'(1);
    end
    newest = sat_val(quot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      not_primed_q <= 1'b1;
      slot_q       <= '0;
      j_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (bearing_o.valid && bearing_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            not_primed_q <= 1'b0;
            state_q      <= ST_ZERO;
          end
        end
        ST_ZERO: state_q <= ST_PREV;
        ST_PREV: begin
          j_q     <= '0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          if (j_q == CNT_END) begin
            state_q <= ST_FIX;
          end else begin
            j_q <= j_q + cnt_t'(1);
          end
        end
        ST_FIX: state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            slot_q  <= base_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cur_q  <= slot_q;
          base_q <= slot_add(slot_q, OFF_ONE);
          if (not_primed_q) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
              ring_q[i] <= wrapped;
            end
          end else begin
            ring_q[slot_q] <= wrapped;
          end
        end
      end
      ST_ZERO: ring_q[cur_q] <= zero_fix;
      ST_PREV: p_q <= rd_val;
      ST_FIX: begin
        for (int i = 0; i < RING_DEPTH; i++) begin
          if (acc_hi) begin
            ring_q[i] <= sat_val(hdf_pkg::acc_t'(ring_q[i]) - TURN_A);
          end else if (acc_neg) begin
            ring_q[i] <= sat_val(hdf_pkg::acc_t'(ring_q[i]) + TURN_A);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_q         <= newest;
          ring_q[cur_q] <= newest;
        end
      end
      default: ;
    endcase
  end

endmodule
